[hw/rtl/sqd_pkg.sv]
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types, constants and helpers of the shortest-queue SJF dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

    localparam int JOB_TYPES   = 3;
    localparam int MAX_QUEUES  = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int CFG_REGS    = 3;

    localparam int NQ        = JOB_TYPES * MAX_QUEUES;
    localparam int QI_W      = $clog2(NQ);
    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = QI_W + SLOT_W;
    localparam int RAM_DEPTH = NQ * (2 ** SLOT_W);
    localparam int TIME_W    = 32;
    localparam int ENTRY_W   = 56;
    localparam int PADDR_W   = 4;

    // slot entry: {arrival time, service time, job id}
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [CFG_REGS-1:0][1:0] cfg_t;

    typedef enum logic [1:0] {
        ACT_ARRIVE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        EV_ENQUEUED  = 3'd0,
        EV_DROPPED   = 3'd1,
        EV_COMPLETED = 3'd2,
        EV_STARTED   = 3'd3,
        EV_STATS     = 3'd4,
        EV_TICK_END  = 3'd5
    } event_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ARR_SCAN,
        S_ARR_CHK,
        S_ARR_CMP,
        S_ARR_PUT,
        S_ARR_UPD,
        S_ARR_EMIT,
        S_DROP_EMIT,
        S_QRY_EMIT,
        S_TK_DONE,
        S_TK_START,
        S_TK_HEAD,
        S_TK_SWR,
        S_TK_UPD,
        S_TK_SEMIT,
        S_TK_NEXT,
        S_TK_END
    } state_t;

    typedef struct packed {
        event_t      ev;
        logic [15:0] job;
        logic [1:0]  qtype;
        logic [1:0]  queue;
        logic [31:0] wait_val;
        logic        use_stats;
        logic        last;
    } emit_t;

    function automatic logic [1:0] active_queues(input cfg_t cfg, input logic [1:0] t);
        logic [1:0] n;
        n = 2'd1;
        if (32'(t) < CFG_REGS)
        begin
            n = cfg[t];
        end
        if (n == 2'd0)
        begin
            n = 2'd1;
        end
        if (32'(n) > MAX_QUEUES)
        begin
            n = 2'(MAX_QUEUES);
        end
        return n;
    endfunction

endpackage

[hw/rtl/sqd_slot_ram.sv]
// ----------------------------------------------------------------------------
// sqd_slot_ram
// Queue slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sqd_slot_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [sqd_pkg::ADDR_W-1:0] waddr,
    input  sqd_pkg::entry_t            wdata,
    input  logic [sqd_pkg::ADDR_W-1:0] raddr,
    output sqd_pkg::entry_t            rdata
);

    sqd_pkg::entry_t mem [sqd_pkg::RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/sqd_engine.sv]
// ----------------------------------------------------------------------------
// sqd_engine
// Sequencer: queue selection, sorted insert, tick sweep, result register.
// ----------------------------------------------------------------------------
module sqd_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  sqd_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    action,
    input  logic [15:0]   job_id,
    input  logic [1:0]    job_type,
    input  logic [7:0]    service_time,
    input  logic [1:0]    query_queue,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [2:0]    event_res,
    output logic [15:0]   out_job_id,
    output logic [1:0]    out_type,
    output logic [1:0]    out_queue,
    output logic [31:0]   event_time,
    output logic [31:0]   job_wait,
    output logic [4:0]    waiting_now,
    output logic [15:0]   enqueued_total,
    output logic [4:0]    peak_waiting,
    output logic [31:0]   wait_sum,
    output logic          last
);

    localparam int CNT_W  = sqd_pkg::CNT_W;
    localparam int QI_W   = sqd_pkg::QI_W;
    localparam int SLOT_W = sqd_pkg::SLOT_W;
    localparam int NQ     = sqd_pkg::NQ;

    sqd_pkg::state_t state_reg, state_next;
    logic [15:0]  job_reg, job_next;
    logic [1:0]   type_reg, type_next;
    logic [7:0]   svc_reg, svc_next;
    logic [1:0]   q_reg, q_next;
    logic [1:0]   best_reg, best_next;
    logic [CNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic [QI_W-1:0]  qi_reg, qi_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic         stat_ok_reg, stat_ok_next;
    sqd_pkg::entry_t head_reg, head_next;
    logic [31:0]  time_reg;

    // per-queue state
    logic [CNT_W-1:0] cnt_q   [NQ];
    logic             busy_q  [NQ];
    logic [15:0]      sjob_q  [NQ];
    logic [31:0]      sdone_q [NQ];
    logic [15:0]      enq_q   [NQ];
    logic [CNT_W-1:0] peak_q  [NQ];
    logic [31:0]      wsum_q  [NQ];

    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] inc_cnt;
    logic [32:0]      sum_wide;
    logic [31:0]      start_wait;
    logic [1:0]       nact;
    logic [1:0]       best_sel;
    logic             can_emit;

    logic                       ram_we;
    logic [sqd_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    sqd_pkg::entry_t            ram_wdata, ram_rdata, new_entry;

    logic upd_arr, upd_cmp, upd_start, time_inc, emit_en;
    sqd_pkg::emit_t emit;

    sqd_slot_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur_cnt    = cnt_q[qi_reg];
    assign inc_cnt    = cur_cnt + CNT_W'(1);
    assign start_wait = time_reg - head_reg[55:24];
    assign sum_wide   = {1'b0, wsum_q[qi_reg]} + {1'b0, start_wait};
    assign nact       = sqd_pkg::active_queues(cfg, type_reg);
    assign can_emit   = !out_valid || out_ready;
    assign new_entry  = {time_reg, svc_reg, job_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        type_reg     <= type_next;
        svc_reg      <= svc_next;
        q_reg        <= q_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
        qi_reg       <= qi_next;
        idx_reg      <= idx_next;
        stat_ok_reg  <= stat_ok_next;
        head_reg     <= head_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        type_next     = type_reg;
        svc_next      = svc_reg;
        q_next        = q_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        qi_next       = qi_reg;
        idx_next      = idx_reg;
        stat_ok_next  = stat_ok_reg;
        head_next     = head_reg;
        best_sel      = best_reg;
        in_ready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {qi_reg, idx_reg[SLOT_W-1:0]};
        ram_wdata     = new_entry;
        ram_raddr     = {qi_reg, idx_reg[SLOT_W-1:0]};
        upd_arr       = 1'b0;
        upd_cmp       = 1'b0;
        upd_start     = 1'b0;
        time_inc      = 1'b0;
        emit_en       = 1'b0;
        emit          = '{ev: sqd_pkg::EV_STATS, job: job_reg, qtype: type_reg,
                          queue: q_reg, wait_val: 32'd0, use_stats: stat_ok_reg,
                          last: 1'b1};

        unique case (state_reg)
            sqd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    job_next  = job_id;
                    type_next = job_type;
                    svc_next  = service_time;
                    q_next    = 2'd0;
                    unique case (sqd_pkg::action_t'(action))
                        sqd_pkg::ACT_ARRIVE:
                        begin
                            qi_next = QI_W'(32'(job_type) * sqd_pkg::MAX_QUEUES);
                            if (32'(job_type) < sqd_pkg::JOB_TYPES)
                            begin
                                state_next = sqd_pkg::S_ARR_SCAN;
                            end
                            else
                            begin
                                stat_ok_next = 1'b0;
                                state_next   = sqd_pkg::S_DROP_EMIT;
                            end
                        end
                        sqd_pkg::ACT_TICK:
                        begin
                            type_next  = 2'd0;
                            qi_next    = '0;
                            state_next = sqd_pkg::S_TK_DONE;
                        end
                        sqd_pkg::ACT_QUERY:
                        begin
                            q_next       = query_queue;
                            stat_ok_next = (32'(job_type) < sqd_pkg::JOB_TYPES) &&
                                           (32'(query_queue) < sqd_pkg::MAX_QUEUES);
                            qi_next      = QI_W'(32'(job_type) * sqd_pkg::MAX_QUEUES
                                                 + 32'(query_queue));
                            state_next   = sqd_pkg::S_QRY_EMIT;
                        end
                        default:
                        begin
                            state_next = sqd_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // one queue count compared per cycle; strict less keeps the lowest index
            sqd_pkg::S_ARR_SCAN:
            begin
                if (q_reg == 2'd0 || cur_cnt < best_cnt_reg)
                begin
                    best_sel      = q_reg;
                    best_cnt_next = cur_cnt;
                end
                best_next = best_sel;
                if (q_reg == nact - 2'd1)
                begin
                    qi_next    = QI_W'(32'(type_reg) * sqd_pkg::MAX_QUEUES + 32'(best_sel));
                    state_next = sqd_pkg::S_ARR_CHK;
                end
                else
                begin
                    q_next  = q_reg + 2'd1;
                    qi_next = qi_reg + QI_W'(1);
                end
            end

            sqd_pkg::S_ARR_CHK:
            begin
                q_next       = best_reg;
                stat_ok_next = 1'b1;
                idx_next     = cur_cnt;
                if (32'(cur_cnt) >= sqd_pkg::QUEUE_DEPTH)
                begin
                    state_next = sqd_pkg::S_DROP_EMIT;
                end
                else if (cur_cnt == '0)
                begin
                    state_next = sqd_pkg::S_ARR_PUT;
                end
                else
                begin
                    ram_raddr  = {qi_reg, SLOT_W'(cur_cnt - CNT_W'(1))};
                    state_next = sqd_pkg::S_ARR_CMP;
                end
            end

            // walk down from the tail, shifting entries not shorter than the new job
            sqd_pkg::S_ARR_CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata[23:16] >= svc_reg)
                begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - CNT_W'(1);
                    if (idx_reg == CNT_W'(1))
                    begin
                        state_next = sqd_pkg::S_ARR_PUT;
                    end
                    else
                    begin
                        ram_raddr = {qi_reg, SLOT_W'(idx_reg - CNT_W'(2))};
                    end
                end
                else
                begin
                    state_next = sqd_pkg::S_ARR_UPD;
                end
            end

            sqd_pkg::S_ARR_PUT:
            begin
                ram_we     = 1'b1;
                state_next = sqd_pkg::S_ARR_UPD;
            end

            sqd_pkg::S_ARR_UPD:
            begin
                upd_arr    = 1'b1;
                state_next = sqd_pkg::S_ARR_EMIT;
            end

            sqd_pkg::S_ARR_EMIT:
            begin
                emit.ev = sqd_pkg::EV_ENQUEUED;
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    state_next = sqd_pkg::S_IDLE;
                end
            end

            sqd_pkg::S_DROP_EMIT:
            begin
                emit.ev = sqd_pkg::EV_DROPPED;
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    state_next = sqd_pkg::S_IDLE;
                end
            end

            sqd_pkg::S_QRY_EMIT:
            begin
                emit.job = 16'd0;
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    state_next = sqd_pkg::S_IDLE;
                end
            end

            sqd_pkg::S_TK_DONE:
            begin
                emit.ev        = sqd_pkg::EV_COMPLETED;
                emit.job       = sjob_q[qi_reg];
                emit.use_stats = 1'b1;
                emit.last      = 1'b0;
                if (busy_q[qi_reg] && time_reg >= sdone_q[qi_reg])
                begin
                    if (can_emit)
                    begin
                        emit_en    = 1'b1;
                        upd_cmp    = 1'b1;
                        state_next = sqd_pkg::S_TK_START;
                    end
                end
                else
                begin
                    state_next = sqd_pkg::S_TK_START;
                end
            end

            sqd_pkg::S_TK_START:
            begin
                idx_next  = CNT_W'(1);
                ram_raddr = {qi_reg, SLOT_W'(0)};
                if (!busy_q[qi_reg] && cur_cnt != '0)
                begin
                    state_next = sqd_pkg::S_TK_HEAD;
                end
                else
                begin
                    state_next = sqd_pkg::S_TK_NEXT;
                end
            end

            sqd_pkg::S_TK_HEAD:
            begin
                head_next = ram_rdata;
                ram_raddr = {qi_reg, SLOT_W'(idx_reg)};
                if (idx_reg < cur_cnt)
                begin
                    state_next = sqd_pkg::S_TK_SWR;
                end
                else
                begin
                    state_next = sqd_pkg::S_TK_UPD;
                end
            end

            // one entry moves toward the head per cycle
            sqd_pkg::S_TK_SWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {qi_reg, SLOT_W'(idx_reg - CNT_W'(1))};
                ram_wdata = ram_rdata;
                ram_raddr = {qi_reg, SLOT_W'(idx_reg + CNT_W'(1))};
                idx_next  = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) >= cur_cnt)
                begin
                    state_next = sqd_pkg::S_TK_UPD;
                end
            end

            sqd_pkg::S_TK_UPD:
            begin
                upd_start  = 1'b1;
                state_next = sqd_pkg::S_TK_SEMIT;
            end

            sqd_pkg::S_TK_SEMIT:
            begin
                emit.ev        = sqd_pkg::EV_STARTED;
                emit.job       = head_reg[15:0];
                emit.wait_val  = start_wait;
                emit.use_stats = 1'b1;
                emit.last      = 1'b0;
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    state_next = sqd_pkg::S_TK_NEXT;
                end
            end

            sqd_pkg::S_TK_NEXT:
            begin
                state_next = sqd_pkg::S_TK_DONE;
                if (q_reg == nact - 2'd1)
                begin
                    if (32'(type_reg) == sqd_pkg::JOB_TYPES - 1)
                    begin
                        state_next = sqd_pkg::S_TK_END;
                    end
                    else
                    begin
                        type_next = type_reg + 2'd1;
                        q_next    = 2'd0;
                        qi_next   = QI_W'((32'(type_reg) + 1) * sqd_pkg::MAX_QUEUES);
                    end
                end
                else
                begin
                    q_next  = q_reg + 2'd1;
                    qi_next = qi_reg + QI_W'(1);
                end
            end

            sqd_pkg::S_TK_END:
            begin
                emit.ev        = sqd_pkg::EV_TICK_END;
                emit.job       = 16'd0;
                emit.qtype     = 2'd0;
                emit.queue     = 2'd0;
                emit.use_stats = 1'b0;
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    time_inc   = 1'b1;
                    state_next = sqd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sqd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            for (int i = 0; i < NQ; i++)
            begin
                cnt_q[i]   <= '0;
                busy_q[i]  <= 1'b0;
                sjob_q[i]  <= '0;
                sdone_q[i] <= '0;
                enq_q[i]   <= '0;
                peak_q[i]  <= '0;
                wsum_q[i]  <= '0;
            end
        end
        else
        begin
            if (time_inc)
            begin
                time_reg <= time_reg + 32'd1;
            end
            if (upd_arr)
            begin
                cnt_q[qi_reg] <= inc_cnt;
                if (enq_q[qi_reg] != 16'hFFFF)
                begin
                    enq_q[qi_reg] <= enq_q[qi_reg] + 16'd1;
                end
                if (inc_cnt > peak_q[qi_reg])
                begin
                    peak_q[qi_reg] <= inc_cnt;
                end
            end
            if (upd_cmp)
            begin
                busy_q[qi_reg] <= 1'b0;
            end
            if (upd_start)
            begin
                cnt_q[qi_reg]   <= cur_cnt - CNT_W'(1);
                wsum_q[qi_reg]  <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                busy_q[qi_reg]  <= 1'b1;
                sjob_q[qi_reg]  <= head_reg[15:0];
                sdone_q[qi_reg] <= time_reg + 32'(head_reg[23:16]);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (emit_en)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            event_res      <= emit.ev;
            out_job_id     <= emit.job;
            out_type       <= emit.qtype;
            out_queue      <= emit.queue;
            event_time     <= time_reg;
            job_wait       <= emit.wait_val;
            waiting_now    <= emit.use_stats ? 5'(cur_cnt) : 5'd0;
            enqueued_total <= emit.use_stats ? enq_q[qi_reg] : 16'd0;
            peak_waiting   <= emit.use_stats ? 5'(peak_q[qi_reg]) : 5'd0;
            wait_sum       <= emit.use_stats ? wsum_q[qi_reg] : 32'd0;
            last           <= emit.last;
        end
    end

endmodule

[hw/rtl/shortest_queue_sjf_dispatcher_unit.sv]
// Sequence: an arrival scans the active queues of its type, then shifts at most 15
//   entries for its sorted insert; a full queue drops it; a query gives one stats
//   beat; a tick checks each active queue for a completion and a job to start.
// Throughput: one item at a time; the next item is taken the cycle after its
//   final result beat is loaded. A stalled result beat holds the sequencer.
// Reset: asynchronous, active low; counters, busy flags, time cleared, queue regs 1.
// ----------------------------------------------------------------------------
// shortest_queue_sjf_dispatcher_unit
// Join-shortest-queue dispatcher with shortest-job-first ordering per queue.
// ----------------------------------------------------------------------------
module shortest_queue_sjf_dispatcher_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [15:0]                 job_id,
    input  logic [1:0]                  job_type,
    input  logic [7:0]                  service_time,
    input  logic [1:0]                  query_queue,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  event_res,
    output logic [15:0]                 out_job_id,
    output logic [1:0]                  out_type,
    output logic [1:0]                  out_queue,
    output logic [31:0]                 event_time,
    output logic [31:0]                 job_wait,
    output logic [4:0]                  waiting_now,
    output logic [15:0]                 enqueued_total,
    output logic [4:0]                  peak_waiting,
    output logic [31:0]                 wait_sum,
    output logic                        last
);

    sqd_pkg::cfg_t cfg_reg;
    logic [1:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sqd_pkg::CFG_REGS; i++)
            begin
                cfg_reg[i] <= 2'd1;
            end
        end
        else if (wr_en && 32'(reg_idx) < sqd_pkg::CFG_REGS)
        begin
            cfg_reg[reg_idx] <= pwdata[1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (32'(reg_idx) < sqd_pkg::CFG_REGS)
        begin
            prdata = 32'(cfg_reg[reg_idx]);
        end
    end

    sqd_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .job_id         (job_id),
        .job_type       (job_type),
        .service_time   (service_time),
        .query_queue    (query_queue),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .out_job_id     (out_job_id),
        .out_type       (out_type),
        .out_queue      (out_queue),
        .event_time     (event_time),
        .job_wait       (job_wait),
        .waiting_now    (waiting_now),
        .enqueued_total (enqueued_total),
        .peak_waiting   (peak_waiting),
        .wait_sum       (wait_sum),
        .last           (last)
    );

endmodule

[hw/rtl/sqd_checker.sv]
// ----------------------------------------------------------------------------
// sqd_checker
// Port-level checks on the result beats of the dispatcher.
// ----------------------------------------------------------------------------
module sqd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_res,
    input logic [31:0] event_time,
    input logic        last
);

    // a stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(event_time))
    else $error("result beat changed while stalled");

    // only completions and starts may be followed by more beats of the same item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |->
            event_res == sqd_pkg::EV_COMPLETED || event_res == sqd_pkg::EV_STARTED)
    else $error("non-final beat with a single-result event");

    // tick end closes every tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == sqd_pkg::EV_TICK_END |-> last)
    else $error("tick end without last");

    // single-result events always carry last
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == sqd_pkg::EV_ENQUEUED || event_res == sqd_pkg::EV_DROPPED
                      || event_res == sqd_pkg::EV_STATS) |-> last)
    else $error("single-result event without last");

endmodule

bind shortest_queue_sjf_dispatcher_unit sqd_checker u_sqd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .event_time (event_time),
    .last       (last)
);
